>>> rtl/sector_interleave_placement_defines.svh
// Assertion macros used by the RTL of the placement block.
`ifndef SECTOR_INTERLEAVE_PLACEMENT_DEFINES_SVH
`define SECTOR_INTERLEAVE_PLACEMENT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sip_pkg.sv
package sip_pkg;

  localparam int MAX_SECTORS    = 32;
  localparam int ADDR_W         = $clog2(MAX_SECTORS);
  localparam int NUM_SIZE_CODES = 8;
  localparam int GAP_SCALE_DIV  = 128 * 128;
  localparam int GAP_SHIFT      = $clog2(GAP_SCALE_DIV);

  localparam int SECTOR_W = 6;
  localparam int CODE_W   = 3;
  localparam int SLOT_W   = 12;
  localparam int ROT_W    = 6;
  localparam int MIN_W    = 16;
  localparam int MAX_W    = 17;
  localparam int LEN_W    = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTOR_COUNT = 3'd0,
    REG_INTERLEAVE   = 3'd1,
    REG_CHUNK_SIZE   = 3'd2,
    REG_GAP          = 3'd3,
    REG_TRACK_CAP    = 3'd4,
    REG_HDR_BYTES    = 3'd5,
    REG_IDX_BYTES    = 3'd6,
    REG_SIZE_BOUNDS  = 3'd7
  } cfg_reg_t;

endpackage

>>> rtl/sip_req_if.sv
interface sip_req_if;
  logic                          valid;
  logic                          ready;
  logic [sip_pkg::SECTOR_W-1:0]  tail_sector;

  modport source (output valid, output tail_sector, input ready);
  modport sink   (input valid, input tail_sector, output ready);
endinterface

>>> rtl/sip_rsp_if.sv
interface sip_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sip_pkg::SECTOR_W-1:0]  slot_sector;
  logic [sip_pkg::CODE_W-1:0]    slot_size_code;
  logic [sip_pkg::SLOT_W-1:0]    slot_offset;
  logic                          last_slot;
  logic [sip_pkg::ROT_W-1:0]     rotations;
  logic [sip_pkg::MIN_W-1:0]     min_offset;
  logic [sip_pkg::MAX_W-1:0]     high_offset;
  logic [sip_pkg::LEN_W-1:0]     track_length;
  logic                          layout_error;

  modport source (output valid, output slot_sector, output slot_size_code,
                  output slot_offset, output last_slot, output rotations,
                  output min_offset, output high_offset, output track_length,
                  output layout_error, input ready);
  modport sink   (input valid, input slot_sector, input slot_size_code,
                  input slot_offset, input last_slot, input rotations,
                  input min_offset, input high_offset, input track_length,
                  input layout_error, output ready);
endinterface

>>> rtl/sector_interleave_placement.sv
// Sector interleave placement for one track.
// req carries a tail sector id; one word is taken when valid and ready are
// high, and ready is high only while the block is idle. rsp then carries one
// word per slot (sector_count, held to 1..32, words; slot 0 first); the
// last word has last_slot set with rotations, min/max offset, track length
// and the error flag. cfg_we/cfg_index/cfg_data write the eight setup
// registers; the user must write them only while idle, as the block does not
// enforce it. Per word the sequencer clears the slot memory, then for each
// sector brings the position back onto the track and probes the slot memory
// downward (read, then check, wrapping below slot 0) for a free slot, then
// a rotation fixup, then per slot a memory read, the sector size and a
// serial divide for the chunk count; the last slot skips the divide and
// ends with the summary. Next word is taken once the last result is loaded.
// When rsp stalls, the result register holds its word and the sequencer
// waits before loading the next one. Reset (rst, synchronous) sets the
// registers to their defaults and returns to idle; every word clears the
// slot memory itself.
`include "sector_interleave_placement_defines.svh"

module sector_interleave_placement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sip_pkg::CFG_DATA_W-1:0]  cfg_data,
  sip_req_if.sink                         req,
  sip_rsp_if.source                       rsp
);

  localparam int AW  = sip_pkg::ADDR_W;
  localparam int SW  = sip_pkg::SECTOR_W;
  localparam int CW  = sip_pkg::CODE_W;
  localparam int EW  = SW + CW;
  localparam int DW  = 15;   // sector bytes / chunk size width
  localparam int OW  = 20;   // offset in chunks
  localparam int BW  = 21;   // offset in bytes
  localparam int PW  = 23;   // signed slack / max
  localparam int LW  = 24;   // signed length
  localparam int RPW = sip_pkg::ROT_W + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_WRAP, S_PRD, S_PCHK, S_RADJ,
    S_RD, S_LOAD, S_SB, S_ACC, S_DIV, S_STEP, S_FIN1, S_FIN2
  } state_t;

  // configuration registers
  logic [5:0]  sector_count;
  logic [3:0]  interleave;
  logic [14:0] chunk_size;
  logic [11:0] gap;
  logic [15:0] track_cap;
  logic [7:0]  hdr_bytes;
  logic [7:0]  idx_bytes;
  logic [63:0] size_bounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= 6'd1;
      interleave   <= 4'd1;
      chunk_size   <= 15'd512;
      gap          <= 12'd0;
      track_cap    <= 16'd12500;
      hdr_bytes    <= 8'd62;
      idx_bytes    <= 8'd146;
      size_bounds  <= 64'd0;
    end else if (cfg_we) begin
      case (sip_pkg::cfg_reg_t'(cfg_index))
        sip_pkg::REG_SECTOR_COUNT: sector_count <= cfg_data[5:0];
        sip_pkg::REG_INTERLEAVE:   interleave   <= cfg_data[3:0];
        sip_pkg::REG_CHUNK_SIZE:   chunk_size   <= cfg_data[14:0];
        sip_pkg::REG_GAP:          gap          <= cfg_data[11:0];
        sip_pkg::REG_TRACK_CAP:    track_cap    <= cfg_data[15:0];
        sip_pkg::REG_HDR_BYTES:    hdr_bytes    <= cfg_data[7:0];
        sip_pkg::REG_IDX_BYTES:    idx_bytes    <= cfg_data[7:0];
        sip_pkg::REG_SIZE_BOUNDS:  size_bounds  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective settings
  logic [SW-1:0] n;
  logic [3:0]    il;
  logic [DW-1:0] chunk;
  assign n = (sector_count == '0) ? SW'(1) :
             (sector_count > SW'(sip_pkg::MAX_SECTORS)) ? SW'(sip_pkg::MAX_SECTORS) :
             sector_count;
  assign il    = (interleave == '0) ? 4'd1 : interleave;
  assign chunk = (chunk_size == '0) ? DW'(1) : chunk_size;

  // size code: highest code whose bound exceeds the id
  function automatic logic [CW-1:0] code_of(input logic [SW-1:0] id,
                                            input logic [63:0] bounds);
    logic [CW-1:0] c;
    c = '0;
    for (int j = 0; j < sip_pkg::NUM_SIZE_CODES; j++) begin
      if (bounds[8*j +: 8] > {2'b00, id}) c = CW'(j);
    end
    return c;
  endfunction

  // data + scaled gap + header bytes
  function automatic logic [DW-1:0] sector_bytes(input logic [CW-1:0] code,
                                                 input logic [11:0] g,
                                                 input logic [7:0]  hs);
    logic [DW-1:0] data;
    logic [27:0]   prod;
    logic [12:0]   gb;
    data = DW'(128) << code;
    prod = 28'(data) * 28'(g) + 28'(sip_pkg::GAP_SCALE_DIV / 2);
    gb   = 13'(prod >> sip_pkg::GAP_SHIFT);
    return DW'(data + DW'(gb) + DW'(hs));
  endfunction

  // slot memory: {sector id, size code}
  logic [EW-1:0] slot_mem [sip_pkg::MAX_SECTORS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;
  logic [EW-1:0] mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_wa] <= mem_wd;
    mem_q <= slot_mem[mem_ra];
  end

  // sequencer registers
  state_t               state;
  logic [AW-1:0]        clr_cnt;
  logic signed [6:0]    cur;
  logic [SW-1:0]        sec;
  logic [AW-1:0]        pcnt;
  logic [AW-1:0]        lastpos;
  logic                 tail_ne;
  logic [sip_pkg::ROT_W-1:0] rot;
  logic [AW-1:0]        idx;
  logic [SW-1:0]        ent_id;
  logic [CW-1:0]        ent_code;
  logic [DW-1:0]        sb;
  logic [DW-1:0]        dvd;
  logic [DW:0]          rem;
  logic [3:0]           dcnt;
  logic [OW-1:0]        off;
  logic [BW-1:0]        offb;
  logic [BW-1:0]        minv;
  logic [BW-1:0]        tend;
  logic [RPW-1:0]       rprod;
  logic signed [PW-1:0] slack;

  logic                 ov;
  logic [SW-1:0]        o_sector;
  logic [CW-1:0]        o_code;
  logic [sip_pkg::SLOT_W-1:0] o_off;
  logic                 o_last;
  logic [sip_pkg::ROT_W-1:0]  o_rot;
  logic [sip_pkg::MIN_W-1:0]  o_min;
  logic [sip_pkg::MAX_W-1:0]  o_max;
  logic [sip_pkg::LEN_W-1:0]  o_len;
  logic                 o_err;

  // combinational helpers
  logic [SW-1:0]        tail_eff;
  logic                 rot_cnt;       // wrap counts a rotation
  logic [sip_pkg::ROT_W-1:0] rot_inc;
  logic [sip_pkg::ROT_W-1:0] rot_adj1;
  logic [sip_pkg::ROT_W-1:0] rot_adj2;
  logic [SW-1:0]        mem_id;
  logic                 last_idx;
  logic [DW:0]          rem_sh;
  logic signed [PW-1:0] maxv;
  logic signed [LW-1:0] len;
  logic                 err;

  assign tail_eff = (req.tail_sector == '0 || req.tail_sector > n) ? n : req.tail_sector;
  assign rot_cnt  = (sec != n);
  assign rot_inc  = (rot == '1) ? rot : rot + 1'b1;
  assign rot_adj1 = (tail_ne && rot != '1) ? rot + 1'b1 : rot;
  assign rot_adj2 = (tail_ne && il == 4'd2 && lastpos == AW'(1) && rot_adj1 != '1) ?
                    rot_adj1 + 1'b1 : rot_adj1;
  assign mem_id   = mem_q[EW-1:CW];
  assign last_idx = ({1'b0, idx} == n - 1'b1);
  assign rem_sh   = {rem[DW-1:0], dvd[DW-1]};
  assign maxv     = $signed({2'b00, minv}) + slack;
  assign len      = $signed(LW'(rprod)) + $signed(LW'(tend)) - $signed(LW'(minv));
  assign err      = slack < 0 || len < 0;

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
      end
      S_PRD: mem_ra = cur[AW-1:0];
      S_PCHK: begin
        mem_we = (mem_id == '0);
        mem_wa = cur[AW-1:0];
        mem_wd = {sec, code_of(sec, size_bounds)};
      end
      S_RD: mem_ra = idx;
      default: ;
    endcase
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = ov;
  assign rsp.slot_sector    = o_sector;
  assign rsp.slot_size_code = o_code;
  assign rsp.slot_offset    = o_off;
  assign rsp.last_slot      = o_last;
  assign rsp.rotations      = o_rot;
  assign rsp.min_offset     = o_min;
  assign rsp.high_offset    = o_max;
  assign rsp.track_length   = o_len;
  assign rsp.layout_error   = o_err;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      if (ov && rsp.ready) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            tail_ne <= (tail_eff != n);
            sec     <= tail_eff;
            cur     <= $signed({1'b0, n}) - 7'sd1;
            pcnt    <= '0;
            rot     <= '0;
            clr_cnt <= '0;
            state   <= S_CLR;
          end
        end
        // wipe every slot
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_WRAP;
        end
        // bring the position back onto the track
        S_WRAP: begin
          if (cur < 0) begin
            cur <= cur + $signed({1'b0, n});
            if (rot_cnt) rot <= rot_inc;
          end else begin
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PCHK;
        // probe downward for a free slot, or place
        S_PCHK: begin
          if (mem_id != '0) begin
            if (cur == 7'sd0) begin
              cur <= $signed({1'b0, n}) - 7'sd1;
              if (rot_cnt) rot <= rot_inc;
            end else begin
              cur <= cur - 7'sd1;
            end
            state <= S_PRD;
          end else begin
            lastpos <= cur[AW-1:0];
            pcnt    <= pcnt + 1'b1;
            cur     <= cur - $signed({3'b000, il});
            sec     <= (sec == SW'(1)) ? n : sec - 1'b1;
            if ({1'b0, pcnt} == n - 1'b1) state <= S_RADJ;
            else                          state <= S_WRAP;
          end
        end
        S_RADJ: begin
          rot   <= rot_adj2;
          idx   <= '0;
          off   <= '0;
          offb  <= '0;
          minv  <= '0;
          tend  <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          ent_id   <= mem_id;
          ent_code <= mem_q[CW-1:0];
          state    <= S_SB;
        end
        S_SB: begin
          sb    <= sector_bytes(ent_code, gap, hdr_bytes);
          state <= S_ACC;
        end
        // note sector one and sector n, emit a plain slot word unless this is the last slot
        S_ACC: begin
          if (ent_id == SW'(1)) minv <= offb;
          if (ent_id == n)
            tend <= offb + BW'(hdr_bytes) + BW'(idx_bytes) + BW'(sb);
          if (last_idx) begin
            state <= S_FIN1;
          end else if (!ov) begin
            ov       <= 1'b1;
            o_sector <= ent_id;
            o_code   <= ent_code;
            o_off    <= off[sip_pkg::SLOT_W-1:0];
            o_last   <= 1'b0;
            o_rot    <= '0;
            o_min    <= '0;
            o_max    <= '0;
            o_len    <= '0;
            o_err    <= 1'b0;
            dvd      <= sb - 1'b1;
            rem      <= '0;
            dcnt     <= '0;
            state    <= S_DIV;
          end
        end
        // restoring divide of (bytes - 1) by chunk, one bit a cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, chunk}) begin
            rem <= rem_sh - {1'b0, chunk};
            dvd <= {dvd[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dvd <= {dvd[DW-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 4'(DW - 1)) state <= S_STEP;
        end
        // advance by quotient + 1 chunks
        S_STEP: begin
          off   <= off + OW'(dvd) + 1'b1;
          offb  <= offb + BW'(sb) - 1'b1 - BW'(rem) + BW'(chunk);
          idx   <= idx + 1'b1;
          state <= S_RD;
        end
        S_FIN1: begin
          rprod <= RPW'(rot) * RPW'(track_cap);
          slack <= $signed(PW'(track_cap)) - $signed(PW'(offb)) -
                   $signed(PW'(hdr_bytes)) - $signed(PW'(idx_bytes)) - $signed(PW'(1));
          state <= S_FIN2;
        end
        // emit the last slot word with the summary
        S_FIN2: begin
          if (!ov) begin
            ov       <= 1'b1;
            o_sector <= ent_id;
            o_code   <= ent_code;
            o_off    <= off[sip_pkg::SLOT_W-1:0];
            o_last   <= 1'b1;
            o_rot    <= rot;
            o_min    <= minv[sip_pkg::MIN_W-1:0];
            o_max    <= err ? '0 : maxv[sip_pkg::MAX_W-1:0];
            o_len    <= err ? '0 : len[sip_pkg::LEN_W-1:0];
            o_err    <= err;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SIP_ASSERT_NOW(a_probe_in_range, state == S_PRD,
    cur >= 0 && cur < $signed({1'b0, n}), "probe position off the track")
  `SIP_ASSERT_NOW(a_slot_in_range, state == S_RD,
    {1'b0, idx} < n, "slot index past sector count")
  `SIP_ASSERT_NEXT(a_rot_frozen, state == S_RD && !rst,
    $stable(rot), "rotation count moved during offset phase")
  `SIP_ASSERT_NEXT(a_word_held, ov && !rsp.ready,
    ov && $stable(o_sector) && $stable(o_off) && $stable(o_last),
    "result word changed while stalled")

endmodule
